FILE: rtl/skyp_pkg.sv
// Shared constants, codes and types of the skyline profile assembly core.
package skyp_pkg;

  localparam int MAX_EQ    = 1024;
  localparam int EQ_AW     = 10;
  localparam int PROF_AW   = 16;
  localparam int PROF_DEPTH = 65536;
  localparam int TBL_W     = 32;
  localparam int DATA_W    = 32;
  localparam int LOC_W     = 17;

  localparam logic [2:0] OP_BEGIN  = 3'd0;
  localparam logic [2:0] OP_EDGE   = 3'd1;
  localparam logic [2:0] OP_END    = 3'd2;
  localparam logic [2:0] OP_ADD_A  = 3'd3;
  localparam logic [2:0] OP_ADD_B  = 3'd4;
  localparam logic [2:0] OP_READ_A = 3'd5;
  localparam logic [2:0] OP_READ_B = 3'd6;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_IGN  = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [LOC_W-1:0] LOC_MAX = '1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_TCLR  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_SCLR  = 8'b0000_1000,
    S_LOOK  = 8'b0001_0000,
    S_FETCH = 8'b0010_0000,
    S_MATH  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

endpackage

FILE: rtl/skyp_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module skyp_ram #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/skyp_qmul.sv
// Q16.16 multiplier: registered product, then round half up and saturate.
module skyp_qmul
  import skyp_pkg::*;
(
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0] q_r
);

  logic signed [2*DATA_W-1:0] prod_r;
  logic signed [2*DATA_W-1:0] rnd;
  logic signed [2*DATA_W-17:0] shq;
  logic signed [DATA_W-1:0]   q_nxt;

  // round half up by adding one half LSB, then floor shift
  always_comb begin
    rnd = prod_r + 64'sd32768;
    shq = rnd[2*DATA_W-1:16];
    if (!shq[2*DATA_W-17] && (shq[2*DATA_W-18:DATA_W-1] != '0)) begin
      q_nxt = 32'sh7FFF_FFFF;
    end else if (shq[2*DATA_W-17] && (shq[2*DATA_W-18:DATA_W-1] != '1)) begin
      q_nxt = 32'sh8000_0000;
    end else begin
      q_nxt = shq[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    q_r    <= q_nxt;
  end

endmodule

FILE: rtl/skyline_profile_assembly_core.sv
// Top level: sequencer over the column table, profile store and rhs store.
//
//  channel | ports                                 | fields, low bit first
//  in      | in_tvalid/in_tready/in_tuser/in_tdata | tuser: op 3
//          |                                       | tdata: row 11, col 11, value 32, scale 32
//  out     | out_tvalid/out_tready/out_tuser/out_tdata | tuser: status 2
//          |                                       | tdata: read_data 32, location 17
//  cfg     | cfg_we/cfg_wdata                      | num_equations 11
//
// One item at a time: edge passes S_LOOK and S_FETCH, add/read also S_MATH, then S_DONE for output.
// begin_profile sweeps the 1024-entry column table, one entry a cycle.
// end_profile scans n columns (unless already built) and then zeroes the stores up to
// max(profile size, n) entries, one a cycle; an overflow skips the zeroing. After reset a
// table clearing pass runs before the first request is taken. A finished result
// waits in the output register while the next request is accepted.
module skyline_profile_assembly_core
  import skyp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // op
  input  logic [87:0] in_tdata,   // row, col, value, scale
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // status
  output logic [55:0] out_tdata,  // read_data, location
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata   // num_equations
);

  state_t state_r;
  logic        init_r;
  logic [10:0] num_eq_r;
  logic [2:0]  op_r;
  logic [10:0] row_r, col_r;
  logic signed [DATA_W-1:0] val_r, scl_r;
  logic [10:0] cnt_r, n_r, bcnt_r;
  logic [LOC_W:0] ccnt_r, lim_r;
  logic [TBL_W-1:0] sum_r;
  logic [LOC_W-1:0] total_r;
  logic        built_r;
  logic [PROF_AW-1:0] addr_r;
  logic [1:0]  st_r;
  logic [DATA_W-1:0] rd_r;
  logic [LOC_W-1:0] loc_r;
  logic        out_tvalid_r;
  logic [1:0]  out_tuser_r;
  logic [55:0] out_tdata_r;

  logic        accept;
  logic [2:0]  in_op;
  logic [10:0] eff;
  logic        col_we;
  logic [EQ_AW-1:0] col_waddr, col_ra0, col_ra1;
  logic [TBL_W-1:0] col_wdata, tc, tp;
  logic        prof_we, rhs_we;
  logic [PROF_AW-1:0] prof_waddr, prof_raddr;
  logic [EQ_AW-1:0] rhs_waddr, rhs_raddr;
  logic [DATA_W-1:0] prof_wdata, rhs_wdata, prof_rd, rhs_rd;
  logic [DATA_W-1:0] q;
  logic [TBL_W-1:0] scan_sum, cmr, minrow, aaddr;
  logic        edge_ok, edge_upd, a_ok, b_ok;
  logic [DATA_W-1:0] mem_d;
  logic signed [DATA_W:0] acc;
  logic [DATA_W-1:0] acc_sat;
  logic [LOC_W:0] scan_lim, built_lim;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_op     = in_tuser;
  assign eff       = (num_eq_r > 11'(MAX_EQ)) ? 11'(MAX_EQ) : num_eq_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  // column table, duplicated for a second read port
  skyp_ram #(.AW(EQ_AW), .DW(TBL_W)) u_col0 (
    .clk, .we(col_we), .waddr(col_waddr), .wdata(col_wdata), .raddr(col_ra0), .rdata(tc)
  );
  skyp_ram #(.AW(EQ_AW), .DW(TBL_W)) u_col1 (
    .clk, .we(col_we), .waddr(col_waddr), .wdata(col_wdata), .raddr(col_ra1), .rdata(tp)
  );
  skyp_ram #(.AW(PROF_AW), .DW(DATA_W)) u_prof (
    .clk, .we(prof_we), .waddr(prof_waddr), .wdata(prof_wdata), .raddr(prof_raddr),
    .rdata(prof_rd)
  );
  skyp_ram #(.AW(EQ_AW), .DW(DATA_W)) u_rhs (
    .clk, .we(rhs_we), .waddr(rhs_waddr), .wdata(rhs_wdata), .raddr(rhs_raddr),
    .rdata(rhs_rd)
  );

  skyp_qmul u_qmul (.clk, .a(val_r), .b(scl_r), .q_r(q));

  // profile checks and arithmetic on table and store read data
  always_comb begin
    scan_sum = (cnt_r == 11'd1) ? 32'd1 : tc + 32'd1 + sum_r;
    cmr      = 32'(col_r) - 32'(row_r);
    edge_ok  = !built_r && !row_r[10] && !col_r[10] && (row_r < eff) && (col_r < eff);
    edge_upd = edge_ok && (col_r > row_r) && (tc < cmr);
    minrow   = (col_r == 11'd0) ? 32'd0 : 32'(col_r) + 32'd1 - (tc - tp);
    aaddr    = tc - 32'd1 - cmr;
    a_ok     = built_r && !row_r[10] && !col_r[10] && (col_r < bcnt_r)
               && (row_r <= col_r) && (32'(row_r) >= minrow)
               && (aaddr < 32'(PROF_DEPTH)) && (aaddr < 32'(total_r));
    b_ok     = built_r && !row_r[10] && (row_r < bcnt_r);
    mem_d    = (op_r == OP_ADD_A || op_r == OP_READ_A) ? prof_rd : rhs_rd;
    acc      = {mem_d[DATA_W-1], mem_d} + {q[DATA_W-1], q};
    if (acc[DATA_W] != acc[DATA_W-1]) begin
      acc_sat = acc[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      acc_sat = acc[DATA_W-1:0];
    end
    scan_lim  = (scan_sum[LOC_W:0] > {7'd0, n_r}) ? scan_sum[LOC_W:0] : {7'd0, n_r};
    built_lim = ({1'b0, total_r} > {7'd0, bcnt_r}) ? {1'b0, total_r} : {7'd0, bcnt_r};
  end

  // memory port control
  always_comb begin
    col_we     = 1'b0;
    col_waddr  = col_r[EQ_AW-1:0];
    col_wdata  = cmr;
    col_ra0    = (state_r == S_SCAN) ? cnt_r[EQ_AW-1:0] : col_r[EQ_AW-1:0];
    col_ra1    = col_r[EQ_AW-1:0] - 10'd1;
    prof_we    = 1'b0;
    prof_waddr = ccnt_r[PROF_AW-1:0];
    prof_wdata = '0;
    rhs_we     = 1'b0;
    rhs_waddr  = ccnt_r[EQ_AW-1:0];
    rhs_wdata  = '0;
    // fetch the entry while its address is checked, so data lands in S_MATH
    prof_raddr = (state_r == S_FETCH) ? aaddr[PROF_AW-1:0] : addr_r;
    rhs_raddr  = (state_r == S_FETCH) ? row_r[EQ_AW-1:0] : addr_r[EQ_AW-1:0];
    unique case (state_r)
      S_TCLR: begin
        col_we    = 1'b1;
        col_waddr = cnt_r[EQ_AW-1:0];
        col_wdata = '0;
      end
      S_SCAN: begin
        col_we    = (cnt_r != 11'd0);
        col_waddr = 10'(cnt_r - 11'd1);
        col_wdata = scan_sum;
      end
      S_FETCH: begin
        col_we = (op_r == OP_EDGE) && edge_upd;
      end
      S_SCLR: begin
        prof_we = ccnt_r < {1'b0, total_r};
        rhs_we  = ccnt_r < {7'd0, bcnt_r};
      end
      S_MATH: begin
        prof_we    = (op_r == OP_ADD_A);
        prof_waddr = addr_r;
        prof_wdata = acc_sat;
        rhs_we     = (op_r == OP_ADD_B);
        rhs_waddr  = addr_r[EQ_AW-1:0];
        rhs_wdata  = acc_sat;
      end
      default: ;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_eq_r <= '0;
    end else if (cfg_we) begin
      num_eq_r <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_TCLR;
      init_r       <= 1'b1;
      cnt_r        <= '0;
      built_r      <= 1'b0;
      bcnt_r       <= '0;
      total_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // load a finished result, or drop the one taken downstream
      if (state_r == S_DONE && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r  <= in_op;
            row_r <= in_tdata[10:0];
            col_r <= in_tdata[21:11];
            val_r <= in_tdata[53:22];
            scl_r <= in_tdata[85:54];
            st_r  <= ST_DONE;
            rd_r  <= '0;
            loc_r <= '0;
            cnt_r <= '0;
            ccnt_r <= '0;
            if (in_op == OP_BEGIN) begin
              built_r <= 1'b0;
              bcnt_r  <= '0;
              total_r <= '0;
              init_r  <= 1'b0;
              state_r <= S_TCLR;
            end else if (in_op == OP_END) begin
              if (built_r) begin
                lim_r   <= built_lim;
                state_r <= S_SCLR;
              end else if (eff == 11'd0) begin
                built_r <= 1'b1;
                bcnt_r  <= '0;
                total_r <= '0;
                lim_r   <= '0;
                state_r <= S_SCLR;
              end else begin
                n_r     <= eff;
                state_r <= S_SCAN;
              end
            end else begin
              state_r <= S_LOOK;
            end
          end
        end
        S_TCLR: begin
          cnt_r <= cnt_r + 11'd1;
          if (cnt_r[EQ_AW-1:0] == '1) begin
            state_r <= init_r ? S_IDLE : S_DONE;
          end
        end
        S_SCAN: begin
          cnt_r <= cnt_r + 11'd1;
          if (cnt_r != 11'd0) begin
            sum_r <= scan_sum;
          end
          if (cnt_r == n_r) begin
            if (scan_sum > 32'(PROF_DEPTH)) begin
              st_r    <= ST_OVF;
              loc_r   <= (scan_sum > 32'(LOC_MAX)) ? LOC_MAX : scan_sum[LOC_W-1:0];
              total_r <= '0;
              bcnt_r  <= '0;
              state_r <= S_DONE;
            end else begin
              total_r <= scan_sum[LOC_W-1:0];
              bcnt_r  <= n_r;
              built_r <= 1'b1;
              lim_r   <= scan_lim;
              state_r <= S_SCLR;
            end
          end
        end
        S_SCLR: begin
          ccnt_r <= ccnt_r + 18'd1;
          if (ccnt_r + 18'd1 >= lim_r) begin
            loc_r   <= total_r;
            state_r <= S_DONE;
          end
        end
        S_LOOK: begin
          state_r <= S_FETCH;
        end
        S_FETCH: begin
          unique case (op_r) inside
            OP_EDGE: begin
              st_r    <= edge_ok ? ST_DONE : ST_IGN;
              state_r <= S_DONE;
            end
            OP_ADD_A, OP_READ_A: begin
              if (op_r == OP_ADD_A && scl_r == '0) begin
                st_r    <= ST_DONE;
                state_r <= S_DONE;
              end else if (a_ok) begin
                addr_r  <= aaddr[PROF_AW-1:0];
                loc_r   <= aaddr[LOC_W-1:0];
                state_r <= S_MATH;
              end else begin
                st_r    <= ST_IGN;
                state_r <= S_DONE;
              end
            end
            OP_ADD_B, OP_READ_B: begin
              if (op_r == OP_ADD_B && scl_r == '0) begin
                st_r    <= ST_DONE;
                state_r <= S_DONE;
              end else if (b_ok) begin
                addr_r  <= PROF_AW'(row_r[EQ_AW-1:0]);
                loc_r   <= LOC_W'(row_r[EQ_AW-1:0]);
                state_r <= S_MATH;
              end else begin
                st_r    <= ST_IGN;
                state_r <= S_DONE;
              end
            end
            default: begin
              st_r    <= ST_IGN;
              state_r <= S_DONE;
            end
          endcase
        end
        S_MATH: begin
          rd_r    <= (op_r == OP_ADD_A || op_r == OP_ADD_B) ? acc_sat : mem_d;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tuser_r <= st_r;
            out_tdata_r <= {7'd0, loc_r, rd_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a built profile never exceeds the store
  a_total_fits: assert property (@(posedge clk) disable iff (!rst_n)
    built_r |-> ({1'b0, total_r} <= 18'(PROF_DEPTH)))
    else $error("profile size beyond store depth");

  // profile store written only by accumulate or clearing
  a_prof_we: assert property (@(posedge clk) disable iff (!rst_n)
    prof_we |-> (state_r == S_MATH || state_r == S_SCLR))
    else $error("unexpected profile store write");

  // scan counter stays within the frozen equation count
  a_scan_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= n_r))
    else $error("scan ran past equation count");

  // a result leaves as soon as the output register is free
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_tvalid_r || out_tready)) |=> out_tvalid_r)
    else $error("result not delivered");

endmodule
